>>> src/ihfp_pkg.sv
// Shared constants and types for the IMU heading frame parser.
package ihfp_pkg;

    // Default frame geometry
    localparam int FRAME_LEN_DEF = 19;
    localparam int SUM_START_DEF = 2;
    localparam int SUM_END_DEF   = 18;

    // Frame constants
    localparam logic [7:0]         HDR_BYTE      = 8'hAA;
    localparam logic signed [15:0] YAW_MIN       = -16'sd18000;
    localparam logic signed [15:0] YAW_MAX       = 16'sd18000;
    localparam logic [31:0]        TIMEOUT_RESET = 32'd100;

    // Item kinds carried in s_tuser
    localparam logic FUNC_BYTE  = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    // Beat widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 56;

    // Frame decision from the window to the top level
    typedef struct packed {
        logic        frame_ok;
        logic [15:0] yaw;
        logic [15:0] pitch;
        logic [15:0] roll;
    } ihfp_frame_t;

endpackage

>>> src/ihfp_sum_tree.sv
// Balanced adder tree giving the 8-bit wrapping sum of its byte lanes.
module ihfp_sum_tree #(
    parameter int N_LANES = 32
) (
    input  logic [7:0] lanes [N_LANES],
    output logic [7:0] sum
);

    localparam int LEVELS = $clog2(N_LANES);
    localparam int HALF   = N_LANES / 2;

    logic [7:0] node [LEVELS+1][N_LANES];

    // Add pairs level by level, the top half of each level stays zero
    always_comb begin
        for (int i = 0; i < N_LANES; i++) begin
            node[0][i] = lanes[i];
        end
        for (int l = 0; l < LEVELS; l++) begin
            for (int i = 0; i < HALF; i++) begin
                node[l+1][i]      = node[l][2*i] + node[l][2*i+1];
                node[l+1][i+HALF] = '0;
            end
        end
    end

    assign sum = node[LEVELS][0];

endmodule

>>> src/ihfp_window.sv
// Byte window shift line, fill count and frame decision.
module ihfp_window #(
    parameter int FRAME_LEN = ihfp_pkg::FRAME_LEN_DEF,
    parameter int SUM_START = ihfp_pkg::SUM_START_DEF,
    parameter int SUM_END   = ihfp_pkg::SUM_END_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 shift_en,
    input  logic [7:0]           rx_byte,
    output ihfp_pkg::ihfp_frame_t frame
);

    localparam int CNT_W    = $clog2(FRAME_LEN + 1);
    localparam int SPAN_END = (SUM_END < FRAME_LEN) ? SUM_END : FRAME_LEN;
    localparam int TREE_N   = 1 << $clog2(FRAME_LEN);

    logic [7:0]       win_reg [FRAME_LEN];
    logic [7:0]       win_new [FRAME_LEN];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       lanes   [TREE_N];
    logic [7:0]       sum;
    logic             full_after;
    logic             hdr_ok;
    logic             yaw_ok;
    logic [15:0]      yaw;

    // Window as it stands once this byte has entered
    always_comb begin
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            win_new[i] = win_reg[i+1];
        end
        win_new[FRAME_LEN-1] = rx_byte;
    end

    // Feed the checksum span to the tree, zero elsewhere
    for (genvar g = 0; g < TREE_N; g++) begin : g_lane
        if (g >= SUM_START && g < SPAN_END) begin : g_used
            assign lanes[g] = win_new[g];
        end else begin : g_zero
            assign lanes[g] = '0;
        end
    end

    ihfp_sum_tree #(
        .N_LANES (TREE_N)
    ) u_sum_tree (
        .lanes (lanes),
        .sum   (sum)
    );

    // Frame decision on the updated window
    assign full_after = (count_reg >= CNT_W'(FRAME_LEN - 1));
    assign hdr_ok     = (win_new[0] == ihfp_pkg::HDR_BYTE) &&
                        (win_new[1] == ihfp_pkg::HDR_BYTE);
    assign yaw        = {win_new[4], win_new[3]};
    assign yaw_ok     = ($signed(yaw) >= ihfp_pkg::YAW_MIN) &&
                        ($signed(yaw) <= ihfp_pkg::YAW_MAX);

    assign frame.frame_ok = full_after && hdr_ok && yaw_ok &&
                            (sum == win_new[FRAME_LEN-1]);
    assign frame.yaw      = yaw;
    assign frame.pitch    = {win_new[6], win_new[5]};
    assign frame.roll     = {win_new[8], win_new[7]};

    // Saturate the fill count, empty it on an accepted frame
    always_comb begin
        if (frame.frame_ok) begin
            count_next = '0;
        end else if (full_after) begin
            count_next = CNT_W'(FRAME_LEN);
        end else begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (shift_en) begin
            count_reg <= count_next;
        end
    end

    // Shift the window, no reset on the payload
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            for (int i = 0; i < FRAME_LEN; i++) begin
                win_reg[i] <= win_new[i];
            end
        end
    end

endmodule

>>> src/imu_heading_frame_parser.sv
// Top level of the IMU heading frame parser: handshake, staleness and result register.
//
// Input beats (s_) carry either a received UART byte with its millisecond
// timestamp (s_tuser = 0) or a staleness check (s_tuser = 1). Every input
// beat gives exactly one result beat on the m_ side, in order.
// Byte beats slide a window of FRAME_LEN bytes; when the updated window has
// two 0xAA header bytes, a matching 8-bit checksum and a yaw within +/-18000,
// m_tuser is 1 and m_tdata holds yaw, pitch and roll in hundredths of a
// degree. The frame time is recorded and the window is emptied.
// Check beats answer timed_out when no frame has arrived within timeout_limit ms
// (the user writes it via cfg_wr_en/cfg_wr_data only while idle; the block does
// not enforce this); a timeout clears the link-valid flag until the next good frame.
// Timing: an accepted beat is held in the input register and moves into the result
// register once that register is free. Throughput is one beat per cycle while
// m_tready is high, set by the single pass from input register through the
// window update and checksum adder tree into the result register.
// Reset (aresetn low, synchronous) empties the window, clears the valid flag
// and time, and sets timeout_limit to 100. While m_tready is low the result
// holds, one more beat is taken into the input register, then s_tready drops.
module imu_heading_frame_parser #(
    parameter int FRAME_LEN = ihfp_pkg::FRAME_LEN_DEF,
    parameter int SUM_START = ihfp_pkg::SUM_START_DEF,
    parameter int SUM_END   = ihfp_pkg::SUM_END_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration: timeout_limit
    input  logic                           cfg_wr_en,
    input  logic [31:0]                    cfg_wr_data,
    // Input channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ihfp_pkg::S_TDATA_W-1:0] s_tdata,  // rx_byte[7:0], now_time[39:8]
    input  logic                           s_tuser,  // func
    // Result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ihfp_pkg::M_TDATA_W-1:0] m_tdata,  // yaw[15:0], pitch[31:16],
                                                     // roll[47:32], timed_out[48],
                                                     // zero [55:49]
    output logic                           m_tuser   // frame_valid
);

    logic        in_valid_reg;
    logic        in_func_reg;
    logic [7:0]  in_byte_reg;
    logic [31:0] in_time_reg;

    logic        out_valid_reg;
    logic        out_frame_reg;
    logic [15:0] out_yaw_reg;
    logic [15:0] out_pitch_reg;
    logic [15:0] out_roll_reg;
    logic        out_tmo_reg;

    logic [31:0] limit_reg;
    logic [31:0] last_time_reg;
    logic [31:0] last_time_next;
    logic        have_valid_reg;
    logic        have_valid_next;

    logic        advance;
    logic        is_byte;
    logic        frame_hit;
    logic        timed_out;
    logic [31:0] elapsed;
    ihfp_pkg::ihfp_frame_t frame;

    // Move the held beat on when the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign is_byte  = (in_func_reg == ihfp_pkg::FUNC_BYTE);

    ihfp_window #(
        .FRAME_LEN (FRAME_LEN),
        .SUM_START (SUM_START),
        .SUM_END   (SUM_END)
    ) u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (advance && is_byte),
        .rx_byte  (in_byte_reg),
        .frame    (frame)
    );

    assign frame_hit = is_byte && frame.frame_ok;

    // Staleness answer and link-valid update
    assign elapsed   = in_time_reg - last_time_reg;
    assign timed_out = !have_valid_reg || (elapsed >= limit_reg);

    always_comb begin
        have_valid_next = have_valid_reg;
        last_time_next  = last_time_reg;
        if (frame_hit) begin
            have_valid_next = 1'b1;
            last_time_next  = in_time_reg;
        end else if (!is_byte && timed_out) begin
            have_valid_next = 1'b0;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_func_reg <= s_tuser;
            in_byte_reg <= s_tdata[7:0];
            in_time_reg <= s_tdata[39:8];
        end
    end

    // Control state: limit, frame time, link-valid flag, result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg      <= ihfp_pkg::TIMEOUT_RESET;
            last_time_reg  <= '0;
            have_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (advance) begin
                last_time_reg  <= last_time_next;
                have_valid_reg <= have_valid_next;
                out_valid_reg  <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    // Result register, angles zero unless a frame was accepted
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_frame_reg <= frame_hit;
            out_yaw_reg   <= frame_hit ? frame.yaw   : 16'd0;
            out_pitch_reg <= frame_hit ? frame.pitch : 16'd0;
            out_roll_reg  <= frame_hit ? frame.roll  : 16'd0;
            out_tmo_reg   <= !is_byte && timed_out;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_frame_reg;
    assign m_tdata  = {7'd0, out_tmo_reg, out_roll_reg, out_pitch_reg, out_yaw_reg};

    // An accepted frame never carries a yaw outside the allowed range
    a_yaw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |->
            ($signed(m_tdata[15:0]) >= ihfp_pkg::YAW_MIN &&
             $signed(m_tdata[15:0]) <= ihfp_pkg::YAW_MAX))
        else $error("accepted frame with yaw out of range");

    // A result is either a frame or a timeout, never both
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser && m_tdata[48]))
        else $error("frame_valid and timed_out both set");

    // A frame that moves on marks the link valid
    a_link: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && frame_hit) |=> have_valid_reg)
        else $error("link not marked valid after a frame");

    // Backpressure only while a beat is held
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a held beat");

endmodule

>>> tb/tb_imu_heading_frame_parser.sv
// Self-checking testbench for the IMU heading frame parser: frame acceptance and link staleness.
module tb_imu_heading_frame_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_LEN   = ihfp_pkg::FRAME_LEN_DEF;
    localparam int SUM_START   = ihfp_pkg::SUM_START_DEF;
    localparam int SUM_END     = ihfp_pkg::SUM_END_DEF;
    localparam int LONG_HOLD   = 400;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic        func;
        logic [7:0]  rx_byte;
        logic [31:0] stamp;
    } serial_beat_t;

    typedef struct packed {
        logic        frame_valid;
        logic [15:0] yaw;
        logic [15:0] pitch;
        logic [15:0] roll;
        logic        timed_out;
    } heading_report_t;

    typedef enum {FLAW_NONE, FLAW_HDR0, FLAW_HDR1, FLAW_SUM} frame_flaw_t;

    logic                           aclk;
    logic                           aresetn     = 1'b0;
    logic                           cfg_wr_en   = 1'b0;
    logic [31:0]                    cfg_wr_data = '0;
    logic                           s_tvalid    = 1'b0;
    logic                           s_tready;
    logic [ihfp_pkg::S_TDATA_W-1:0] s_tdata     = '0;
    logic                           s_tuser     = ihfp_pkg::FUNC_BYTE;
    logic                           m_tvalid;
    logic                           m_tready    = 1'b0;
    logic [ihfp_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tuser;

    // Stimulus and expectation stores
    serial_beat_t    beats_to_send[$];
    heading_report_t reports_due[$];
    serial_beat_t    cur_beat = '0;

    // Parser shadow state
    logic [7:0]  frame_win [FRAME_LEN];
    int          win_fill       = 0;
    logic [31:0] last_fix_ms    = '0;
    bit          fix_held       = 1'b0;
    logic [31:0] stale_limit_ms = ihfp_pkg::TIMEOUT_RESET;

    // Handshake bookkeeping
    bit  beat_taken   = 1'b0;
    bit  result_taken = 1'b0;
    bit  offering     = 1'b0;
    bit  tx_calm      = 1'b0;
    bit  rx_calm      = 1'b0;
    bit  rx_hold_req  = 1'b0;
    int  send_gap     = 0;
    int  take_gap     = 0;
    int  hold_left    = 0;
    int  mismatches   = 0;
    int  cycle_count  = 0;

    // Stimulus timebase
    logic [31:0] wall_ms    = 32'd1000;
    logic [31:0] est_fix_ms = '0;

    imu_heading_frame_parser uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Work out the report for one beat and advance the shadow state
    function automatic heading_report_t parse_beat(serial_beat_t b);
        heading_report_t    r;
        logic [7:0]         csum;
        logic signed [15:0] yaw_v;
        logic [31:0]        elapsed;
        int                 i;
        r = '0;
        if (b.func == ihfp_pkg::FUNC_CHECK) begin
            elapsed = b.stamp - last_fix_ms;
            if (!fix_held) begin
                r.timed_out = 1'b1;
            end else if (elapsed >= stale_limit_ms) begin
                // latch staleness so a wrapped clock cannot revive the link
                fix_held    = 1'b0;
                r.timed_out = 1'b1;
            end
            return r;
        end
        if (win_fill >= FRAME_LEN) begin
            for (i = 0; i < FRAME_LEN - 1; i++)
                frame_win[i] = frame_win[i + 1];
            frame_win[FRAME_LEN - 1] = b.rx_byte;
        end else begin
            frame_win[win_fill] = b.rx_byte;
            win_fill++;
            if (win_fill < FRAME_LEN)
                return r;
        end
        csum = '0;
        for (i = SUM_START; i < SUM_END && i < FRAME_LEN; i++)
            csum += frame_win[i];
        yaw_v = {frame_win[4], frame_win[3]};
        if (frame_win[0] == ihfp_pkg::HDR_BYTE && frame_win[1] == ihfp_pkg::HDR_BYTE
                && csum == frame_win[FRAME_LEN - 1]
                && yaw_v >= ihfp_pkg::YAW_MIN && yaw_v <= ihfp_pkg::YAW_MAX) begin
            r.frame_valid = 1'b1;
            r.yaw         = yaw_v;
            r.pitch       = {frame_win[6], frame_win[5]};
            r.roll        = {frame_win[8], frame_win[7]};
            last_fix_ms   = b.stamp;
            fix_held      = 1'b1;
            win_fill      = 0;
        end
        return r;
    endfunction

    // Idle length before the next beat; calm stretches give back-to-back beats
    function automatic int next_gap(inout bit calm);
        if ($urandom_range(0, 15) == 0)
            calm = !calm;
        return calm ? 0 : int'($urandom_range(0, 13));
    endfunction

    task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatches++;
        end
    endtask

    function automatic logic [31:0] next_stamp();
        wall_ms += $urandom_range(0, 3);
        return wall_ms;
    endfunction

    task automatic queue_byte(logic [7:0] value, logic [31:0] stamp);
        beats_to_send.push_back('{func: ihfp_pkg::FUNC_BYTE, rx_byte: value, stamp: stamp});
    endtask

    task automatic queue_check(logic [31:0] stamp);
        beats_to_send.push_back('{func: ihfp_pkg::FUNC_CHECK, rx_byte: 8'($urandom),
                                  stamp: stamp});
    endtask

    // Build one frame with a valid checksum, then spoil it as asked
    task automatic queue_frame(logic [15:0] yaw_w, logic [15:0] pitch_w,
                               logic [15:0] roll_w, frame_flaw_t flaw);
        logic [7:0]  fb [FRAME_LEN];
        logic [7:0]  csum;
        logic [31:0] st;
        int          i;
        fb[0] = ihfp_pkg::HDR_BYTE;
        fb[1] = ihfp_pkg::HDR_BYTE;
        for (i = 2; i < FRAME_LEN; i++)
            fb[i] = 8'($urandom);
        fb[3] = yaw_w[7:0];
        fb[4] = yaw_w[15:8];
        fb[5] = pitch_w[7:0];
        fb[6] = pitch_w[15:8];
        fb[7] = roll_w[7:0];
        fb[8] = roll_w[15:8];
        csum  = '0;
        for (i = SUM_START; i < SUM_END; i++)
            csum += fb[i];
        fb[FRAME_LEN - 1] = csum;
        case (flaw)
            FLAW_HDR0: fb[0] ^= 8'($urandom_range(1, 255));
            FLAW_HDR1: fb[1] ^= 8'($urandom_range(1, 255));
            FLAW_SUM:  fb[FRAME_LEN - 1] ^= 8'($urandom_range(1, 255));
            default: ;
        endcase
        st = wall_ms;
        for (i = 0; i < FRAME_LEN; i++) begin
            st = next_stamp();
            queue_byte(fb[i], st);
        end
        if (flaw == FLAW_NONE && $signed(yaw_w) >= ihfp_pkg::YAW_MIN
                && $signed(yaw_w) <= ihfp_pkg::YAW_MAX)
            est_fix_ms = st;
    endtask

    // Mostly well-formed frames, with checks, corrupted frames and stray bytes mixed in
    task automatic stream_traffic(int n);
        int          count;
        int          pick;
        int          run;
        logic [15:0] yaw_w;
        logic [31:0] st;
        frame_flaw_t flaw;
        count = 0;
        while (count < n) begin
            if ($urandom_range(0, 19) == 0)
                wall_ms = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                case ($urandom_range(0, 9))
                    0:       yaw_w = ihfp_pkg::YAW_MAX;
                    1:       yaw_w = ihfp_pkg::YAW_MIN;
                    2:       yaw_w = ihfp_pkg::YAW_MAX + 16'sd1;
                    3:       yaw_w = ihfp_pkg::YAW_MIN - 16'sd1;
                    4:       yaw_w = 16'($urandom);
                    default: yaw_w = 16'($urandom_range(0, 36000)) + ihfp_pkg::YAW_MIN;
                endcase
                case ($urandom_range(0, 19))
                    0:       flaw = FLAW_HDR0;
                    1:       flaw = FLAW_HDR1;
                    2, 3:    flaw = FLAW_SUM;
                    default: flaw = FLAW_NONE;
                endcase
                queue_frame(yaw_w, 16'($urandom), 16'($urandom), flaw);
                count += FRAME_LEN;
            end else if (pick < 82) begin
                case ($urandom_range(0, 5))
                    0:       st = est_fix_ms + stale_limit_ms - 32'd1;
                    1:       st = est_fix_ms + stale_limit_ms;
                    2:       st = est_fix_ms + stale_limit_ms + 32'd1;
                    3:       st = wall_ms;
                    4:       st = $urandom;
                    default: st = est_fix_ms + $urandom_range(0, 200);
                endcase
                queue_check(st);
                count++;
            end else begin
                run = $urandom_range(1, 6);
                repeat (run) begin
                    queue_byte(($urandom_range(0, 3) == 0) ? ihfp_pkg::HDR_BYTE
                                                           : 8'($urandom),
                               next_stamp());
                end
                count += run;
            end
        end
    endtask

    // Hold until nothing is queued, on the wire or outstanding
    task automatic wait_drained();
        while (beats_to_send.size() != 0 || offering || reports_due.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_timeout(logic [31:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        stale_limit_ms = value;
    endtask

    // Record accepted input beats and check result beats
    always @(posedge aclk) begin
        heading_report_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                result_taken = 1'b1;
                if (reports_due.size() == 0) begin
                    $error("result beat with no report outstanding");
                    mismatches++;
                end else begin
                    want = reports_due.pop_front();
                    check_field("frame_valid", 16'(want.frame_valid), 16'(m_tuser));
                    check_field("yaw", want.yaw, m_tdata[15:0]);
                    check_field("pitch", want.pitch, m_tdata[31:16]);
                    check_field("roll", want.roll, m_tdata[47:32]);
                    check_field("timed_out", 16'(want.timed_out), 16'(m_tdata[48]));
                end
            end
            if (s_tvalid && s_tready) begin
                reports_due.push_back(parse_beat(cur_beat));
                beat_taken = 1'b1;
            end
        end
    end

    // Input driver: advance to the next queued beat after each handshake
    always @(negedge aclk) begin
        if (aresetn) begin
            if (beat_taken) begin
                beat_taken = 1'b0;
                offering   = 1'b0;
                send_gap   = next_gap(tx_calm);
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (beats_to_send.size() != 0) begin
                    cur_beat = beats_to_send.pop_front();
                    offering = 1'b1;
                end
            end
            s_tvalid <= offering;
            s_tdata  <= {cur_beat.stamp, cur_beat.rx_byte};
            s_tuser  <= cur_beat.func;
        end
    end

    // Result receiver: random stalls per beat, plus one long hold on request
    always @(negedge aclk) begin
        if (result_taken) begin
            result_taken = 1'b0;
            take_gap     = next_gap(rx_calm);
        end
        if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (take_gap > 0) begin
            take_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL imu_heading_frame_parser");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: no frame yet, extreme angles, staleness boundary and latch
        queue_check(wall_ms);
        queue_frame(ihfp_pkg::YAW_MAX, 16'h8000, 16'h7FFF, FLAW_NONE);
        queue_check(est_fix_ms + stale_limit_ms - 32'd1);
        queue_check(est_fix_ms + stale_limit_ms);
        queue_check(est_fix_ms + 32'd1);
        wait_drained();

        write_timeout(32'd0);
        stream_traffic(150);
        wait_drained();

        // Long receiver hold while the sender keeps offering
        write_timeout(32'hFFFF_FFFF);
        rx_hold_req = 1'b1;
        stream_traffic(200);
        wait_drained();

        // Run the timestamp across its wrap
        write_timeout(32'd1);
        wall_ms = 32'hFFFF_FF00;
        stream_traffic(150);
        wait_drained();

        write_timeout(32'($urandom_range(2, 5000)));
        stream_traffic(250);
        wait_drained();

        write_timeout(ihfp_pkg::TIMEOUT_RESET);
        stream_traffic(200);
        wait_drained();

        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS imu_heading_frame_parser");
        else
            $display("FAIL imu_heading_frame_parser");
        $finish;
    end

endmodule
